// ===== rtl/sparse_morton_offset_table_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef SPARSE_MORTON_OFFSET_TABLE_MACROS_SVH
`define SPARSE_MORTON_OFFSET_TABLE_MACROS_SVH

// Check that a condition never holds out of reset
`define SOT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

// Check that a implies b in the same cycle
`define SOT_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication violated");

// Check that a implies b in the next cycle
`define SOT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/sot_pkg.sv =====
package sot_pkg;

  // Defaults for the top level parameters
  localparam int SOT_MAX_LEVELS  = 10;
  localparam int SOT_TABLE_DEPTH = 2048;

  // Fixed field widths
  localparam int GRID_W    = 11;
  localparam int KEY_W     = 30;
  localparam int CODE_W    = 31;
  localparam int ENTRIES_W = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  // Operation codes
  localparam logic OP_BUILD  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Start pulses from the control to the workers
  typedef struct packed {
    logic build;
    logic lookup;
  } sot_start_t;

endpackage

// ===== rtl/sot_ram.sv =====
module sot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sot_walk.sv =====
module sot_walk import sot_pkg::*; #(
  parameter int MAX_LEVELS  = SOT_MAX_LEVELS,
  parameter int TABLE_DEPTH = SOT_TABLE_DEPTH,
  localparam int CW    = MAX_LEVELS + 1,
  localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
  localparam int DW    = $clog2(MAX_LEVELS + 1),
  localparam int SW    = 3 * MAX_LEVELS,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sot_start_t        start_i,
  input  logic [GRID_W-1:0] grid_x_i,
  input  logic [GRID_W-1:0] grid_y_i,
  input  logic [GRID_W-1:0] grid_z_i,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output logic [2*SW-1:0]   ram_wdata_o,
  output logic [CNT_W-1:0]  count_o,
  output logic              overflow_o,
  output logic              done_o
);

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_STEP  = 2'd1;
  localparam logic [1:0] W_CLIMB = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [LW-1:0]    top_q, top_d;
  logic [DW-1:0]    depth_q, depth_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             pend_q, pend_d;
  logic             done_q, done_d;
  logic [SW-1:0]    boxes_q, boxes_d;
  logic [SW-1:0]    off_q, off_d;

  // Walk stack: child number and low corner of each level's cube
  logic [2:0]            child_q [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] bx_q [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] by_q [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] bz_q [MAX_LEVELS];

  logic                  st_we, st_base_we;
  logic [LW-1:0]         st_idx;
  logic [2:0]            st_child;
  logic [MAX_LEVELS-1:0] st_bx, st_by, st_bz;

  // Effective grid sizes and their maxima
  logic [CW-1:0]         gx, gy, gz, biggest;
  logic [MAX_LEVELS-1:0] mx, my, mz;
  logic [DW-1:0]         depth_calc;

  function automatic logic [CW-1:0] eff_dim(input logic [GRID_W-1:0] r);
    logic [CW-1:0] g;
    if (r == '0) begin
      g = CW'(1);
    end else if (32'(r) > (32'd1 << MAX_LEVELS)) begin
      g = CW'(1) << MAX_LEVELS;
    end else begin
      g = CW'(r);
    end
    return g;
  endfunction

  always_comb begin
    gx = eff_dim(grid_x_i);
    gy = eff_dim(grid_y_i);
    gz = eff_dim(grid_z_i);
    mx = MAX_LEVELS'(gx - CW'(1));
    my = MAX_LEVELS'(gy - CW'(1));
    mz = MAX_LEVELS'(gz - CW'(1));
    biggest = gx;
    if (gy > biggest) biggest = gy;
    if (gz > biggest) biggest = gz;
    depth_calc = '0;
    for (int d = 0; d < MAX_LEVELS; d++) begin
      if ((CW'(1) << d) < biggest) depth_calc = depth_calc + DW'(1);
    end
  end

  // Octant under test at the top of the stack
  logic [2:0]            cur_child;
  logic [DW-1:0]         lg;
  logic [DW+1:0]         lg3;
  logic [CW-1:0]         len, xlo, ylo, zlo;
  logic [SW-1:0]         vol;
  logic                  full, empty;

  always_comb begin
    cur_child = child_q[top_q];
    lg  = DW'(depth_q - DW'(1) - DW'(top_q));
    lg3 = (DW+2)'(lg) + (DW+2)'({lg, 1'b0});
    len = CW'(1) << lg;
    vol = SW'(1) << lg3;
    xlo = CW'(bx_q[top_q]) + (cur_child[0] ? len : '0);
    ylo = CW'(by_q[top_q]) + (cur_child[1] ? len : '0);
    zlo = CW'(bz_q[top_q]) + (cur_child[2] ? len : '0);
    full = (CW'(mx) >= xlo + len - CW'(1)) && (CW'(my) >= ylo + len - CW'(1)) &&
           (CW'(mz) >= zlo + len - CW'(1));
    empty = (CW'(mx) < xlo) || (CW'(my) < ylo) || (CW'(mz) < zlo);
  end

  // Sequence the walk
  always_comb begin
    state_d  = state_q;
    top_d    = top_q;
    depth_d  = depth_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    pend_d   = pend_q;
    boxes_d  = boxes_q;
    off_d    = off_q;
    done_d   = 1'b0;
    st_we      = 1'b0;
    st_base_we = 1'b0;
    st_idx     = top_q;
    st_child   = cur_child + 3'd1;
    st_bx      = '0;
    st_by      = '0;
    st_bz      = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = IDX_W'(count_q);
    ram_wdata_o = {boxes_q, off_q};
    unique case (state_q)
      W_IDLE: begin
        if (start_i.build) begin
          depth_d  = depth_calc;
          count_d  = CNT_W'(1);
          ovf_d    = 1'b0;
          pend_d   = 1'b0;
          boxes_d  = '0;
          off_d    = '0;
          top_d    = '0;
          st_we      = 1'b1;
          st_base_we = 1'b1;
          st_idx     = '0;
          st_child   = '0;
          if (depth_calc == '0) begin
            done_d = 1'b1;
          end else begin
            state_d = W_STEP;
          end
        end
      end
      W_STEP: begin
        if (!full && !empty && lg != '0) begin
          // Split: push the octant as a new level
          st_we      = 1'b1;
          st_base_we = 1'b1;
          st_idx     = LW'(top_q + LW'(1));
          st_child   = '0;
          st_bx      = MAX_LEVELS'(xlo);
          st_by      = MAX_LEVELS'(ylo);
          st_bz      = MAX_LEVELS'(zlo);
          top_d      = LW'(top_q + LW'(1));
        end else begin
          if (full) begin
            if (pend_q) begin
              if (count_q < CNT_W'(TABLE_DEPTH)) begin
                ram_we_o = 1'b1;
                count_d  = count_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
              pend_d = 1'b0;
            end
            boxes_d = boxes_q + vol;
          end else if (empty) begin
            pend_d = 1'b1;
            off_d  = off_q + vol;
          end
          // Advance to the next sibling; after the last one, climb or finish
          if (cur_child != 3'd7) begin
            st_we = 1'b1;
          end else if (top_q == '0) begin
            done_d  = 1'b1;
            state_d = W_IDLE;
          end else begin
            top_d   = top_q - LW'(1);
            state_d = W_CLIMB;
          end
        end
      end
      W_CLIMB: begin
        if (cur_child != 3'd7) begin
          st_we   = 1'b1;
          state_d = W_STEP;
        end else if (top_q == '0) begin
          done_d  = 1'b1;
          state_d = W_IDLE;
        end else begin
          top_d = top_q - LW'(1);
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      top_q   <= '0;
      depth_q <= '0;
      count_q <= CNT_W'(1);
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      depth_q <= depth_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Hold the running sums and the stack
  always_ff @(posedge clk_i) begin
    boxes_q <= boxes_d;
    off_q   <= off_d;
    if (st_we) begin
      child_q[st_idx] <= st_child;
    end
    if (st_base_we) begin
      bx_q[st_idx] <= st_bx;
      by_q[st_idx] <= st_by;
      bz_q[st_idx] <= st_bz;
    end
  end

  assign count_o    = count_q;
  assign overflow_o = ovf_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/sot_search.sv =====
module sot_search import sot_pkg::*; #(
  parameter int TABLE_DEPTH = SOT_TABLE_DEPTH,
  parameter int SW          = 3 * SOT_MAX_LEVELS,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int SUMW  = ((SW > KEY_W) ? SW : KEY_W) + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sot_start_t        start_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  logic [2*SW-1:0]   ram_rdata_i,
  output logic [CODE_W-1:0] code_o,
  output logic              done_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, span;
  logic [KEY_W-1:0] key_q, key_d;
  logic [SW-1:0]    off_q, off_d;
  logic             done_q, done_d;
  logic [SW-1:0]    rd_start, rd_off;
  logic [SUMW-1:0]  sum;

  assign rd_start = ram_rdata_i[2*SW-1:SW];
  assign rd_off   = ram_rdata_i[SW-1:0];
  assign span     = hi_q - lo_q;

  // Halve the range one memory read at a time
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    off_d   = off_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i.lookup) begin
          key_d   = key_i;
          lo_d    = '0;
          hi_d    = count_i;
          off_d   = '0;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (span > CNT_W'(1)) begin
          mid_d   = lo_q + (span >> 1);
          state_d = S_WAIT;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WAIT: begin
        if (SUMW'(rd_start) <= SUMW'(key_q)) begin
          lo_d  = mid_q;
          off_d = rd_off;
        end else begin
          hi_d = mid_q;
        end
        state_d = S_TEST;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
    off_q <= off_d;
  end

  assign ram_raddr_o = IDX_W'(mid_d);
  assign sum    = SUMW'(key_q) + SUMW'(off_q);
  assign code_o = CODE_W'(sum);
  assign done_o = done_q;

endmodule

// ===== rtl/sparse_morton_offset_table.sv =====
// Channel  | valid      | stall       | payload
// input    | in_valid_i | in_stall_o  | operation_i, box_index_i
// output   | out_valid_o| out_stall_i | morton_code_o, table_entries_o, table_overflow_o
// config   | cfg_we_i   | (none)      | cfg_idx_i, cfg_data_i
//
// One item at a time. A lookup runs a binary search loop over the table memory,
// one read per step. A build is run by the walk sequencer, which visits the
// octree nodes and climbs out of finished levels; a single-box grid needs no walk.
// Reset gives an empty table (one zero entry) and no clearing pass.
// A stalled result waits in the output register; a new item is taken meanwhile.
`include "sparse_morton_offset_table_macros.svh"

module sparse_morton_offset_table import sot_pkg::*; #(
  parameter int MAX_LEVELS  = SOT_MAX_LEVELS,
  parameter int TABLE_DEPTH = SOT_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GRID_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [KEY_W-1:0]     box_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CODE_W-1:0]    morton_code_o,
  output logic [ENTRIES_W-1:0] table_entries_o,
  output logic                 table_overflow_o
);

  localparam int SW    = 3 * MAX_LEVELS;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_BUILD = 2'd1;
  localparam logic [1:0] T_LOOK  = 2'd2;
  localparam logic [1:0] T_HOLD  = 2'd3;

  logic [GRID_W-1:0] grid_x_q, grid_y_q, grid_z_q;
  logic [1:0]        state_q, state_d;
  logic              op_q, op_d;
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] code_q;
  logic [ENTRIES_W-1:0] entries_q;
  logic              ovf_q;
  logic              load;
  logic              out_free;
  sot_start_t        start;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [2*SW-1:0]   ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  count;
  logic              overflow, walk_done, look_done;
  logic [CODE_W-1:0] look_code;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= GRID_W'(1);
      grid_y_q <= GRID_W'(1);
      grid_z_q <= GRID_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_X: grid_x_q <= cfg_data_i;
        REG_GRID_Y: grid_y_q <= cfg_data_i;
        REG_GRID_Z: grid_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sot_ram #(
    .WIDTH(2 * SW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sot_walk #(
    .MAX_LEVELS (MAX_LEVELS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .grid_x_i   (grid_x_q),
    .grid_y_i   (grid_y_q),
    .grid_z_i   (grid_z_q),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .count_o    (count),
    .overflow_o (overflow),
    .done_o     (walk_done)
  );

  sot_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .SW         (SW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .key_i      (box_index_i),
    .count_i    (count),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .code_o     (look_code),
    .done_o     (look_done)
  );

  assign in_stall_o = (state_q != T_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Dispatch transactions and collect results
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    load         = 1'b0;
    start.build  = 1'b0;
    start.lookup = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i;
          if (operation_i == OP_BUILD) begin
            start.build = 1'b1;
            state_d     = T_BUILD;
          end else begin
            start.lookup = 1'b1;
            state_d      = T_LOOK;
          end
        end
      end
      T_BUILD, T_LOOK: begin
        if ((state_q == T_BUILD) ? walk_done : look_done) begin
          if (out_free) begin
            load    = 1'b1;
            state_d = T_IDLE;
          end else begin
            state_d = T_HOLD;
          end
        end
      end
      T_HOLD: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      op_q        <= OP_BUILD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q    <= (op_q == OP_LOOKUP) ? look_code : '0;
      entries_q <= ENTRIES_W'(count);
      ovf_q     <= overflow;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign morton_code_o    = code_q;
  assign table_entries_o  = entries_q;
  assign table_overflow_o = ovf_q;

  `SOT_ASSERT_IMPLY(a_no_write_in_lookup, clk_i, rst_ni, state_q == T_LOOK, !ram_we)
  `SOT_ASSERT_NEVER(a_count_range, clk_i, rst_ni,
                    (count == '0) || (32'(count) > TABLE_DEPTH))
  `SOT_ASSERT_NEXT(a_idle_no_result, clk_i, rst_ni, (state_q == T_IDLE) && !out_valid_q,
                   !out_valid_q)

endmodule

// ===== bench/sparse_morton_offset_table_chk.sv =====
`timescale 1ns / 1ps

module sparse_morton_offset_table_chk import sot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GRID_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 operation_i,
  input  logic [KEY_W-1:0]     box_index_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [CODE_W-1:0]    morton_code_i,
  input  logic [ENTRIES_W-1:0] table_entries_i,
  input  logic                 table_overflow_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int LEVELS = SOT_MAX_LEVELS;
  localparam int DEPTH  = SOT_TABLE_DEPTH;

  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [ENTRIES_W-1:0] entries;
    logic                 overflow;
  } morton_result_t;

  // Shadow of the block's grid registers and offset table
  logic [GRID_W-1:0] grid_sz [3];
  longint            seg_start [DEPTH];
  longint            seg_skip [DEPTH];
  longint            seg_count;
  logic              seg_overflow;

  // Octree walk stack
  longint            lvl_child [LEVELS];
  longint            lvl_len [LEVELS];
  longint            lvl_x [LEVELS];
  longint            lvl_y [LEVELS];
  longint            lvl_z [LEVELS];

  morton_result_t    results_due [$];

  function automatic longint clamp_dim(logic [GRID_W-1:0] r);
    longint g;
    g = longint'(r);
    if (g == 0) g = 1;
    if (g > (64'd1 << LEVELS)) g = 64'd1 << LEVELS;
    return g;
  endfunction

  function automatic void add_segment(longint start, longint skip);
    if (seg_count < DEPTH) begin
      seg_start[seg_count] = start;
      seg_skip[seg_count]  = skip;
      seg_count++;
    end else begin
      seg_overflow = 1'b1;
    end
  endfunction

  // Walk the enclosing cube depth first, record a segment after each gap
  function automatic void rebuild_segments();
    longint mx, my, mz, big, lvls, len, xh, yh, zh, xl, yl, zl, half, filled, skipped;
    int     sp;
    bit     gap_open, pushed;
    mx = clamp_dim(grid_sz[0]) - 1;
    my = clamp_dim(grid_sz[1]) - 1;
    mz = clamp_dim(grid_sz[2]) - 1;
    big = mx;
    if (my > big) big = my;
    if (mz > big) big = mz;
    big++;
    lvls = 0;
    while (lvls < LEVELS && (64'd1 << lvls) < big) lvls++;
    seg_start[0] = 0;
    seg_skip[0] = 0;
    seg_count = 1;
    seg_overflow = 1'b0;
    if (lvls == 0) return;
    filled = 0;
    skipped = 0;
    gap_open = 0;
    sp = 0;
    lvl_child[0] = 0;
    lvl_len[0] = 64'd1 << (lvls - 1);
    lvl_x[0] = lvl_len[0];
    lvl_y[0] = lvl_len[0];
    lvl_z[0] = lvl_len[0];
    while (sp >= 0) begin
      len = lvl_len[sp];
      xh = lvl_x[sp] + (lvl_child[sp][0] ? len : 0);
      yh = lvl_y[sp] + (lvl_child[sp][1] ? len : 0);
      zh = lvl_z[sp] + (lvl_child[sp][2] ? len : 0);
      xl = xh - len;
      yl = yh - len;
      zl = zh - len;
      pushed = 0;
      if (mx >= xh - 1 && my >= yh - 1 && mz >= zh - 1) begin
        if (gap_open) begin
          add_segment(filled, skipped);
          gap_open = 0;
        end
        filled += len * len * len;
      end else if (mx < xl || my < yl || mz < zl) begin
        gap_open = 1;
        skipped += len * len * len;
      end else if (sp + 1 < LEVELS && len > 1) begin
        half = len >> 1;
        sp++;
        lvl_child[sp] = 0;
        lvl_len[sp] = half;
        lvl_x[sp] = xl + half;
        lvl_y[sp] = yl + half;
        lvl_z[sp] = zl + half;
        pushed = 1;
      end
      // Step to the next sibling, climb out of finished levels
      if (!pushed) begin
        while (sp >= 0) begin
          lvl_child[sp]++;
          if (lvl_child[sp] < 8) break;
          sp--;
        end
      end
    end
  endfunction

  function automatic longint skip_for(longint key);
    longint lo, hi, mid;
    lo = 0;
    hi = seg_count;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (seg_start[mid] <= key) lo = mid;
      else hi = mid;
    end
    return seg_skip[lo];
  endfunction

  assign pending_o = results_due.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    morton_result_t r;
    morton_result_t want;
    if (!rst_ni) begin
      grid_sz[0] <= GRID_W'(1);
      grid_sz[1] <= GRID_W'(1);
      grid_sz[2] <= GRID_W'(1);
      seg_start[0] = 0;
      seg_skip[0] = 0;
      seg_count = 1;
      seg_overflow = 1'b0;
      fail_count_o <= 0;
      results_due.delete();
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_X: grid_sz[0] <= cfg_data_i;
          REG_GRID_Y: grid_sz[1] <= cfg_data_i;
          REG_GRID_Z: grid_sz[2] <= cfg_data_i;
          default: ;
        endcase
      end
      // Predict each accepted transaction
      if (in_valid_i && !in_stall_i) begin
        r.code = '0;
        if (operation_i == OP_BUILD) rebuild_segments();
        else r.code = CODE_W'(longint'(box_index_i) + skip_for(longint'(box_index_i)));
        r.entries = ENTRIES_W'(seg_count);
        r.overflow = seg_overflow;
        results_due.insert(results_due.size(), r);
      end
      // Compare each accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result with no transaction pending");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = results_due.pop_front();
          if (morton_code_i !== want.code) begin
            $error("morton_code: expected %0d, got %0d", want.code, morton_code_i);
            fail_count_o <= fail_count_o + 1;
          end else if (table_entries_i !== want.entries) begin
            $error("table_entries: expected %0d, got %0d", want.entries, table_entries_i);
            fail_count_o <= fail_count_o + 1;
          end else if (table_overflow_i !== want.overflow) begin
            $error("table_overflow: expected %0d, got %0d", want.overflow,
                   table_overflow_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/sparse_morton_offset_table_tb.sv =====
`timescale 1ns / 1ps

module sparse_morton_offset_table_tb import sot_pkg::*;;

  localparam int WATCHDOG = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_GRID_X;
  logic [GRID_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i = OP_BUILD;
  logic [KEY_W-1:0]     box_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CODE_W-1:0]    morton_code_o;
  logic [ENTRIES_W-1:0] table_entries_o;
  logic                 table_overflow_o;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  int                   stall_left = 0;
  bit                   quiet = 0;
  longint               grid_boxes = 1;

  sparse_morton_offset_table uut (.*);

  sparse_morton_offset_table_chk chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .box_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .morton_code_i(morton_code_o),
    .table_entries_i(table_entries_o), .table_overflow_i(table_overflow_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  // Hold off results for a random number of cycles per transaction
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = quiet ? 0 : $urandom_range(0, 16);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= (stall_left != 0);
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic op, logic [KEY_W-1:0] key);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    box_index_i <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write all three sizes while idle, then rebuild
  task automatic set_grid(logic [GRID_W-1:0] x, logic [GRID_W-1:0] y,
                          logic [GRID_W-1:0] z);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_GRID_X;
    cfg_data_i <= x;
    @(posedge clk_i);
    cfg_idx_i <= REG_GRID_Y;
    cfg_data_i <= y;
    @(posedge clk_i);
    cfg_idx_i <= REG_GRID_Z;
    cfg_data_i <= z;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_boxes = (x == 0 ? 1 : x) * (y == 0 ? 1 : y) * (z == 0 ? 1 : z);
    send(OP_BUILD, KEY_W'($urandom));
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return KEY_W'($urandom);
      1: return '1;
      2: return '0;
      default: return KEY_W'($urandom_range(0, int'(grid_boxes + 8)));
    endcase
  endfunction

  initial begin
    logic [GRID_W-1:0] gx, gy, gz;
    int lookups;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Table right after reset
    send(OP_LOOKUP, '0);
    send(OP_LOOKUP, '1);
    send(OP_BUILD, '0);
    send(OP_LOOKUP, 30'h2AAAAAAA);
    // Zero sizes count as one
    set_grid(GRID_W'(0), GRID_W'(0), GRID_W'(0));
    send(OP_LOOKUP, 30'h15555555);
    // Odd sizes leave gaps
    set_grid(GRID_W'(3), GRID_W'(5), GRID_W'(7));
    send(OP_LOOKUP, 30'd20);
    send(OP_LOOKUP, 30'd104);
    // Oversized and largest sizes
    set_grid(GRID_W'(2047), GRID_W'(1), GRID_W'(2));
    send(OP_LOOKUP, 30'd2047);
    set_grid(GRID_W'(1), GRID_W'(1024), GRID_W'(1));
    send(OP_LOOKUP, 30'd1023);
    set_grid(GRID_W'(1), GRID_W'(3), GRID_W'(1024));
    send(OP_LOOKUP, '1);
    // Flat plane overruns the table
    set_grid(GRID_W'(128), GRID_W'(128), GRID_W'(1));
    send(OP_LOOKUP, 30'd16383);
    send(OP_LOOKUP, '1);
    send(OP_BUILD, '0);

    // Random phases, mostly small grids
    for (int ph = 0; ph < 40; ph++) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0: begin
          gx = GRID_W'($urandom_range(40, 128));
          gy = GRID_W'($urandom_range(40, 128));
          gz = GRID_W'(1);
        end
        1: begin
          gx = GRID_W'($urandom_range(1000, 2047));
          gy = GRID_W'($urandom_range(0, 2));
          gz = GRID_W'($urandom_range(0, 2));
        end
        default: begin
          gx = GRID_W'($urandom_range(0, 20));
          gy = GRID_W'($urandom_range(0, 20));
          gz = GRID_W'($urandom_range(0, 20));
        end
      endcase
      set_grid(gx, gy, gz);
      lookups = $urandom_range(30, 48);
      for (int i = 0; i < lookups; i++) begin
        if ($urandom_range(0, 40) == 0) send(OP_BUILD, KEY_W'($urandom));
        else send(OP_LOOKUP, pick_key());
      end
    end
    quiet = 0;
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
